@@ design/rgwc_pkg.sv @@
// Shared types and constants for the RTT gradient window controller.
package rgwc_pkg;

  localparam int WIN_W    = 20;
  localparam int RTT_W    = 48;
  localparam int COUNT_W  = 32;
  localparam int COEF_W   = 16;
  localparam int SPW_W    = 8;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  // Register indexes (byte address is 4 * index)
  localparam logic [2:0] REG_MIN_WINDOW   = 3'd0;
  localparam logic [2:0] REG_MAX_WINDOW   = 3'd1;
  localparam logic [2:0] REG_INIT_WINDOW  = 3'd2;
  localparam logic [2:0] REG_STEP_COEF    = 3'd3;
  localparam logic [2:0] REG_SPW          = 3'd4;
  localparam logic [2:0] REG_SMOOTHING    = 3'd5;

  localparam logic [WIN_W-1:0]  MIN_WINDOW_RST  = 20'd1;
  localparam logic [WIN_W-1:0]  MAX_WINDOW_RST  = 20'd1024;
  localparam logic [WIN_W-1:0]  INIT_WINDOW_RST = 20'd16;
  localparam logic [COEF_W-1:0] STEP_COEF_RST   = 16'd4096;
  localparam logic [SPW_W-1:0]  SPW_RST         = 8'd16;
  localparam logic [COEF_W-1:0] SMOOTHING_RST   = 16'd655;

  // Gradient limits in Q1.16
  localparam logic [16:0] GRAD_ONE  = 17'h10000;
  localparam logic [16:0] GRAD_HALF = 17'h08000;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_ERROR  = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [RTT_W-1:0] rtt_ns;
  } rgwc_req_t;

  typedef struct packed {
    logic [WIN_W-1:0]   window;
    logic               shrank;
    logic [COUNT_W-1:0] shrink_count;
  } rgwc_res_t;

endpackage

@@ design/rtt_gradient_window_controller.sv @@
// RTT gradient window controller: top level with serial shared-adder datapath.
//
// Requests arrive on in_req_i under in_valid_i / in_stall_o; each carries an
// error event or an RTT sample. Every request yields exactly one result on
// out_res_o under out_valid_o / out_stall_i: the window after the request, a
// shrink flag and the saturating shrink count.
// Error events, zero samples, samples that do not close a sample window and
// the sample that sets the baseline finish in the cycle they are accepted;
// the result is registered. A sample that closes a window after the baseline
// is set runs a gradient division, a square root, two products and the
// baseline blend, all one bit per cycle through a single shared adder:
// in_stall_o stays high from the accept until the result is loaded (the
// division is skipped when the gradient saturates).
// A result waiting under out_stall_i does not block a new request; a second
// finished result then waits inside until the output register frees up.
// Configuration is an APB port; pready is always high, writes land on the
// access cycle. Writing initial_window also reloads the window.
// Reset (rst_ni low, asynchronous) loads the register defaults, sets the
// window to initial_window and clears baseline, sample count and shrink count.
module rtt_gradient_window_controller #(
  parameter int RTT_BITS    = 48,
  parameter int WINDOW_BITS = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  rgwc_pkg::rgwc_req_t                 in_req_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output rgwc_pkg::rgwc_res_t                 out_res_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rgwc_pkg::ADDR_W-1:0]         paddr,
  input  logic [rgwc_pkg::DATA_W-1:0]         pwdata,
  output logic [rgwc_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  localparam int WW  = rgwc_pkg::WIN_W;
  localparam int AW  = (RTT_BITS + 16 > 42) ? RTT_BITS + 16 : 42;
  localparam int NWW = AW - 20;
  localparam logic [WW:0] WinMax = (WINDOW_BITS >= WW) ? {1'b0, {WW{1'b1}}} :
                                   (WW+1)'((64'd1 << WINDOW_BITS) - 64'd1);

  typedef enum logic [3:0] {
    S_IDLE, S_GRAD, S_DIV, S_SQRT, S_MUL_G, S_MUL_C,
    S_CLAMP, S_BLEND_A, S_BLEND_B, S_OUT
  } state_e;

  function automatic logic [WW-1:0] sat_win(input logic [WW:0] v);
    logic [WW-1:0] r;
    r = (v > WinMax) ? WinMax[WW-1:0] : v[WW-1:0];
    return r;
  endfunction

  state_e state_q, state_d;

  logic [WW-1:0]              min_win_q, min_win_d, max_win_q, max_win_d;
  logic [WW-1:0]              init_win_q, init_win_d;
  logic [rgwc_pkg::COEF_W-1:0] coef_q, coef_d, smooth_q, smooth_d;
  logic [rgwc_pkg::SPW_W-1:0] spw_q, spw_d;

  logic [WW-1:0]              eff_q, eff_d;
  logic [RTT_BITS-1:0]        base_q, base_d, minrtt_q, minrtt_d;
  logic [rgwc_pkg::SPW_W-1:0] scnt_q, scnt_d;
  logic [rgwc_pkg::COUNT_W-1:0] total_q, total_d;
  logic                       shr_q, shr_d;
  logic                       out_valid_q, out_load;
  rgwc_pkg::rgwc_res_t        out_q, out_d;

  logic [AW-1:0]              acc_q, acc_d, opa_q, opa_d;
  logic [16:0]                mul_q, mul_d, g_q, g_d;
  logic [17:0]                res_q, res_d;
  logic [RTT_BITS-1:0]        obs_q, obs_d;
  logic [4:0]                 cnt_q, cnt_d;

  // shared adder / subtractor
  logic [AW-1:0] alu_a, alu_b;
  logic          alu_sub;
  logic [AW:0]   alu_sum;
  logic          alu_ge;

  logic                       cfg_wr, out_free;
  logic [2:0]                 cfg_idx;
  logic [RTT_BITS-1:0]        rtt_in, new_min;
  logic [rgwc_pkg::SPW_W-1:0] spw_eff, scnt_inc;
  logic                       win_done;
  logic [WW-1:0]              half_win, err_win;
  logic [rgwc_pkg::COUNT_W-1:0] total_inc;
  logic [NWW-1:0]             nw;
  logic [WW-1:0]              lim_hi, lim_lo, clamp_win;
  logic [15:0]                q16;

  assign cfg_wr   = psel && penable && pwrite;
  assign cfg_idx  = paddr[4:2];
  assign pready   = 1'b1;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  always_comb begin
    unique case (cfg_idx)
      rgwc_pkg::REG_MIN_WINDOW:  prdata = 32'(min_win_q);
      rgwc_pkg::REG_MAX_WINDOW:  prdata = 32'(max_win_q);
      rgwc_pkg::REG_INIT_WINDOW: prdata = 32'(init_win_q);
      rgwc_pkg::REG_STEP_COEF:   prdata = 32'(coef_q);
      rgwc_pkg::REG_SPW:         prdata = 32'(spw_q);
      rgwc_pkg::REG_SMOOTHING:   prdata = 32'(smooth_q);
      default:                   prdata = '0;
    endcase
  end

  // per-request arithmetic
  assign rtt_in    = RTT_BITS'(in_req_i.rtt_ns);
  assign spw_eff   = (spw_q == '0) ? 8'd1 : spw_q;
  assign new_min   = (scnt_q == '0 || rtt_in < minrtt_q) ? rtt_in : minrtt_q;
  assign scnt_inc  = scnt_q + 8'd1;
  assign win_done  = (scnt_inc >= spw_eff);
  assign half_win  = {1'b0, eff_q[WW-1:1]};
  assign err_win   = sat_win({1'b0, (half_win < min_win_q) ? min_win_q : half_win});
  assign total_inc = (total_q != '1) ? total_q + 32'd1 : total_q;

  // window clamp: max first, then min, so min wins
  assign nw        = acc_q[AW-1:20];
  assign lim_hi    = (nw > NWW'(max_win_q)) ? max_win_q : nw[WW-1:0];
  assign lim_lo    = (lim_hi < min_win_q) ? min_win_q : lim_hi;
  assign clamp_win = sat_win({1'b0, lim_lo});

  always_comb begin
    alu_a   = acc_q;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      S_DIV: begin
        alu_a   = AW'({acc_q[RTT_BITS-1:0], 1'b0});
        alu_b   = AW'(obs_q);
        alu_sub = 1'b1;
      end
      S_SQRT: begin
        // bring down the next two radicand bits, trial = 4*root + 1
        alu_a   = {acc_q[AW-3:0], opa_q[35:34]};
        alu_b   = AW'({res_q, 2'b01});
        alu_sub = 1'b1;
      end
      S_MUL_G, S_MUL_C, S_BLEND_A, S_BLEND_B: begin
        alu_b = mul_q[0] ? opa_q : '0;
      end
      default: ;
    endcase
  end

  assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (AW+1)'(alu_sub);
  assign alu_ge  = alu_sum[AW];
  assign q16     = {res_q[14:0], alu_ge};

  always_comb begin
    state_d    = state_q;
    min_win_d  = min_win_q;
    max_win_d  = max_win_q;
    init_win_d = init_win_q;
    coef_d     = coef_q;
    spw_d      = spw_q;
    smooth_d   = smooth_q;
    eff_d      = eff_q;
    base_d     = base_q;
    minrtt_d   = minrtt_q;
    scnt_d     = scnt_q;
    total_d    = total_q;
    shr_d      = shr_q;
    acc_d      = acc_q;
    opa_d      = opa_q;
    mul_d      = mul_q;
    g_d        = g_q;
    res_d      = res_q;
    obs_d      = obs_q;
    cnt_d      = cnt_q;
    out_load   = 1'b0;

    if (cfg_wr) begin
      unique case (cfg_idx)
        rgwc_pkg::REG_MIN_WINDOW:  min_win_d = pwdata[WW-1:0];
        rgwc_pkg::REG_MAX_WINDOW:  max_win_d = pwdata[WW-1:0];
        rgwc_pkg::REG_INIT_WINDOW: begin
          init_win_d = pwdata[WW-1:0];
          eff_d      = sat_win({1'b0, pwdata[WW-1:0]});
        end
        rgwc_pkg::REG_STEP_COEF:   coef_d   = pwdata[15:0];
        rgwc_pkg::REG_SPW:         spw_d    = pwdata[7:0];
        rgwc_pkg::REG_SMOOTHING:   smooth_d = pwdata[15:0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          shr_d = 1'b0;
          if (in_req_i.mode == rgwc_pkg::MODE_ERROR) begin
            eff_d    = err_win;
            shr_d    = (err_win < eff_q);
            total_d  = (err_win < eff_q) ? total_inc : total_q;
            scnt_d   = '0;
            minrtt_d = '0;
          end else if (rtt_in != '0) begin
            if (win_done) begin
              scnt_d   = '0;
              minrtt_d = '0;
              if (base_q == '0) begin
                base_d = new_min;
              end else begin
                obs_d   = new_min;
                state_d = S_GRAD;
              end
            end else begin
              scnt_d   = scnt_inc;
              minrtt_d = new_min;
            end
          end
          if (!(in_req_i.mode == rgwc_pkg::MODE_SAMPLE && rtt_in != '0 && win_done &&
                base_q != '0)) begin
            if (out_free) begin
              out_load = 1'b1;
            end else begin
              state_d = S_OUT;
            end
          end
        end
      end

      S_GRAD: begin
        if (base_q >= obs_q || {base_q, 1'b0} < {1'b0, obs_q}) begin
          g_d     = (base_q >= obs_q) ? rgwc_pkg::GRAD_ONE : rgwc_pkg::GRAD_HALF;
          acc_d   = '0;
          res_d   = '0;
          opa_d   = AW'({eff_q, 16'h0000});
          cnt_d   = 5'd17;
          state_d = S_SQRT;
        end else begin
          acc_d   = AW'(base_q);
          res_d   = '0;
          cnt_d   = 5'd15;
          state_d = S_DIV;
        end
      end

      S_DIV: begin
        acc_d = alu_ge ? alu_sum[AW-1:0] : alu_a;
        res_d = {res_q[16:0], alu_ge};
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == '0) begin
          g_d     = {1'b0, q16[15] ? q16 : rgwc_pkg::GRAD_HALF[15:0]};
          acc_d   = '0;
          res_d   = '0;
          opa_d   = AW'({eff_q, 16'h0000});
          cnt_d   = 5'd17;
          state_d = S_SQRT;
        end
      end

      S_SQRT: begin
        acc_d = alu_ge ? alu_sum[AW-1:0] : alu_a;
        opa_d = opa_q << 2;
        res_d = {res_q[16:0], alu_ge};
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == '0) begin
          acc_d   = '0;
          opa_d   = AW'(eff_q);
          mul_d   = g_q;
          cnt_d   = 5'd16;
          state_d = S_MUL_G;
        end
      end

      S_MUL_G, S_MUL_C, S_BLEND_A, S_BLEND_B: begin
        acc_d = alu_sum[AW-1:0];
        opa_d = opa_q << 1;
        mul_d = mul_q >> 1;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == '0) begin
          priority case (state_q)
            S_MUL_G: begin
              // eff * g in Q.16, scaled to Q.20
              acc_d   = alu_sum[AW-1:0] << 4;
              opa_d   = AW'(res_q);
              mul_d   = {1'b0, coef_q};
              cnt_d   = 5'd16;
              state_d = S_MUL_C;
            end
            S_MUL_C: state_d = S_CLAMP;
            S_BLEND_A: begin
              opa_d   = AW'(obs_q);
              mul_d   = {1'b0, smooth_q};
              cnt_d   = 5'd16;
              state_d = S_BLEND_B;
            end
            default: begin
              base_d  = RTT_BITS'(alu_sum[AW-1:16]);
              state_d = S_OUT;
            end
          endcase
        end
      end

      S_CLAMP: begin
        eff_d   = clamp_win;
        shr_d   = (clamp_win < eff_q);
        total_d = (clamp_win < eff_q) ? total_inc : total_q;
        // baseline blend: base*(65536-k) + obs*k, then >> 16
        acc_d   = '0;
        opa_d   = AW'(base_q);
        mul_d   = rgwc_pkg::GRAD_ONE - {1'b0, smooth_q};
        cnt_d   = 5'd16;
        state_d = S_BLEND_A;
      end

      S_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_d.window       = eff_d;
    out_d.shrank       = shr_d;
    out_d.shrink_count = total_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      min_win_q   <= rgwc_pkg::MIN_WINDOW_RST;
      max_win_q   <= rgwc_pkg::MAX_WINDOW_RST;
      init_win_q  <= rgwc_pkg::INIT_WINDOW_RST;
      coef_q      <= rgwc_pkg::STEP_COEF_RST;
      spw_q       <= rgwc_pkg::SPW_RST;
      smooth_q    <= rgwc_pkg::SMOOTHING_RST;
      eff_q       <= sat_win({1'b0, rgwc_pkg::INIT_WINDOW_RST});
      base_q      <= '0;
      minrtt_q    <= '0;
      scnt_q      <= '0;
      total_q     <= '0;
      shr_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      min_win_q  <= min_win_d;
      max_win_q  <= max_win_d;
      init_win_q <= init_win_d;
      coef_q     <= coef_d;
      spw_q      <= spw_d;
      smooth_q   <= smooth_d;
      eff_q      <= eff_d;
      base_q     <= base_d;
      minrtt_q   <= minrtt_d;
      scnt_q     <= scnt_d;
      total_q    <= total_d;
      shr_q      <= shr_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    opa_q <= opa_d;
    mul_q <= mul_d;
    g_q   <= g_d;
    res_q <= res_d;
    obs_q <= obs_d;
    cnt_q <= cnt_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

endmodule
